>>> src/tlrg_pkg.sv
// ----------------------------------------------------------------------------
// tlrg_pkg
// Shared types and constants of the thin-lens ray generator.
// ----------------------------------------------------------------------------
package tlrg_pkg;

    localparam int COMP_WIDTH_DEF = 21;  // default component width, Q.10
    localparam int DIR_FRAC_DEF   = 15;  // default fraction bits of the direction
    localparam int REG_W          = 63;  // width of a vector register
    localparam int IN_W           = 16;  // width of every input field
    localparam int SH_W           = 5;   // normalization shift count, 0..30 (31 for a zero length)
    localparam int NORM_W         = 62;  // normalized squared length
    localparam int ACC_W          = 64;  // root recurrence and final product
    localparam int ROOT_STEPS     = 32;  // digits of the square root
    localparam int ROOT_W         = 31;  // root lies in [2^30, 2^31)
    localparam int RECIP_W        = 33;  // reciprocal lies in (2^31, 2^32]
    localparam int RECIP_STEPS    = 33;
    localparam int REM_W          = 32;
    localparam int RECIP_EXP      = 62;  // reciprocal is 2^62 / root
    localparam int CFG_ADDR_W     = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_EYE    = 3'd0,
        REG_CORNER = 3'd1,
        REG_HSPAN  = 3'd2,
        REG_VSPAN  = 3'd3,
        REG_RIGHT  = 3'd4,
        REG_UP     = 3'd5,
        REG_DOF    = 3'd6
    } t_reg_idx;

    // Control that travels beside the data of every root and divider stage.
    typedef struct packed {
        logic            vld;
        logic            zero;
        logic [SH_W-1:0] sh;
    } t_ctl;

endpackage

>>> src/tlrg_front.sv
// ----------------------------------------------------------------------------
// tlrg_front
// Lens offset, origin, direction vector, squared length and normalization.
// ----------------------------------------------------------------------------
module tlrg_front #(
    parameter int CW = tlrg_pkg::COMP_WIDTH_DEF,
    parameter int DW = tlrg_pkg::COMP_WIDTH_DEF + 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic [tlrg_pkg::IN_W-1:0]     i_u,
    input  logic [tlrg_pkg::IN_W-1:0]     i_v,
    input  logic signed [tlrg_pkg::IN_W-1:0] i_lx,
    input  logic signed [tlrg_pkg::IN_W-1:0] i_ly,
    input  logic [tlrg_pkg::REG_W-1:0]    i_eye,
    input  logic [tlrg_pkg::REG_W-1:0]    i_corner,
    input  logic [tlrg_pkg::REG_W-1:0]    i_hspan,
    input  logic [tlrg_pkg::REG_W-1:0]    i_vspan,
    input  logic [tlrg_pkg::REG_W-1:0]    i_right,
    input  logic [tlrg_pkg::REG_W-1:0]    i_up,
    input  logic                          i_dof,
    output tlrg_pkg::t_ctl                o_ctl,
    output logic [tlrg_pkg::NORM_W-1:0]   o_norm,
    output logic [3*CW-1:0]               o_origin,
    output logic [2:0]                    o_dneg,
    output logic [3*DW-1:0]               o_dabs
);
    import tlrg_pkg::*;

    localparam int PW   = CW + IN_W;      // lens product
    localparam int QW   = CW + IN_W + 1;  // screen product
    localparam int OW   = CW + 2;         // lens offset
    localparam int HW   = CW + 1;         // scaled span
    localparam int GW   = CW + 3;         // unsaturated origin
    localparam int SQ_W = 2 * DW;
    localparam int SW   = 2 * DW + 2;
    localparam logic signed [GW-1:0] ORG_MAX = GW'((1 << (CW - 1)) - 1);
    localparam logic signed [GW-1:0] ORG_MIN = GW'(-(1 << (CW - 1)));

    logic [5:0]               r_vld;
    logic signed [PW-1:0]     r_pr [3];
    logic signed [PW-1:0]     r_pu [3];
    logic signed [QW-1:0]     r_ph [3];
    logic signed [QW-1:0]     r_pv [3];
    logic signed [OW-1:0]     r_off [3];
    logic signed [HW-1:0]     r_hu [3];
    logic signed [HW-1:0]     r_vv [3];
    logic signed [CW-1:0]     r_org3 [3];
    logic signed [DW-1:0]     r_d [3];
    logic [SQ_W-1:0]          r_sq [3];
    logic [3*CW-1:0]          r_org4, r_org5, r_org6;
    logic [2:0]               r_neg4, r_neg5, r_neg6;
    logic [3*DW-1:0]          r_abs4, r_abs5, r_abs6;
    logic [SW-1:0]            r_s;
    logic [NORM_W-1:0]        r_norm;
    logic [SH_W-1:0]          r_sh;
    logic                     r_zero;

    logic signed [OW-1:0]     w_off [3];
    logic signed [HW-1:0]     w_hu [3];
    logic signed [HW-1:0]     w_vv [3];
    logic signed [GW-1:0]     w_org [3];
    logic [NORM_W-1:0]        w_t;
    logic [SH_W-1:0]          w_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_vld};
        end
    end

    // Offset and span products are rounded half up by adding half an LSB and
    // shifting arithmetically.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_off[k] = OW'(((PW + 1)'(r_pr[k]) + (PW + 1)'(r_pu[k])
                            + (PW + 1)'(1 << 14)) >>> 15);
            w_hu[k]  = HW'((r_ph[k] + QW'(1 << 15)) >>> 16);
            w_vv[k]  = HW'((r_pv[k] + QW'(1 << 15)) >>> 16);
            w_org[k] = GW'($signed(i_eye[k*CW +: CW])) + GW'(r_off[k]);
        end
    end

    // The squared length is shifted up by whole bit pairs until one of its two
    // top bits is set.
    always_comb begin
        w_t  = NORM_W'(r_s);
        w_sh = '0;
        for (int j = SH_W - 1; j >= 0; j--) begin
            if ((w_t >> (NORM_W - (2 << j))) == '0) begin
                w_t  = w_t << (2 << j);
                w_sh = w_sh | SH_W'(1 << j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_pr[k] <= i_lx * $signed(i_right[k*CW +: CW]);
                r_pu[k] <= i_ly * $signed(i_up[k*CW +: CW]);
                r_ph[k] <= $signed({1'b0, i_u}) * $signed(i_hspan[k*CW +: CW]);
                r_pv[k] <= $signed({1'b0, i_v}) * $signed(i_vspan[k*CW +: CW]);

                r_off[k] <= i_dof ? w_off[k] : '0;
                r_hu[k]  <= w_hu[k];
                r_vv[k]  <= w_vv[k];

                if (w_org[k] > ORG_MAX) begin
                    r_org3[k] <= CW'(ORG_MAX);
                end else if (w_org[k] < ORG_MIN) begin
                    r_org3[k] <= CW'(ORG_MIN);
                end else begin
                    r_org3[k] <= CW'(w_org[k]);
                end
                r_d[k] <= DW'($signed(i_corner[k*CW +: CW])) + DW'(r_hu[k]) + DW'(r_vv[k])
                          - DW'($signed(i_eye[k*CW +: CW])) - DW'(r_off[k]);

                r_sq[k]               <= SQ_W'(r_d[k] * r_d[k]);
                r_neg4[k]             <= r_d[k][DW-1];
                r_abs4[k*DW +: DW]    <= r_d[k][DW-1] ? DW'(-r_d[k]) : DW'(r_d[k]);
                r_org4[k*CW +: CW]    <= r_org3[k];
            end

            r_s    <= SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
            r_org5 <= r_org4;
            r_neg5 <= r_neg4;
            r_abs5 <= r_abs4;

            r_norm <= w_t;
            r_sh   <= w_sh;
            r_zero <= (r_s == '0);
            r_org6 <= r_org5;
            r_neg6 <= r_neg5;
            r_abs6 <= r_abs5;
        end
    end

    assign o_ctl.vld  = r_vld[5];
    assign o_ctl.zero = r_zero;
    assign o_ctl.sh   = r_sh;
    assign o_norm     = r_norm;
    assign o_origin   = r_org6;
    assign o_dneg     = r_neg6;
    assign o_dabs     = r_abs6;

endmodule

>>> src/tlrg_isqrt.sv
// ----------------------------------------------------------------------------
// tlrg_isqrt
// Pipelined square root, one result digit per stage.
// ----------------------------------------------------------------------------
module tlrg_isqrt #(
    parameter int TAG_W = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  tlrg_pkg::t_ctl              i_ctl,
    input  logic [tlrg_pkg::NORM_W-1:0] i_norm,
    input  logic [TAG_W-1:0]            i_tag,
    output tlrg_pkg::t_ctl              o_ctl,
    output logic [tlrg_pkg::ROOT_W-1:0] o_root,
    output logic [TAG_W-1:0]            o_tag
);
    import tlrg_pkg::*;

    logic [ACC_W-1:0] r_n   [ROOT_STEPS-1];
    logic [ACC_W-1:0] r_res [ROOT_STEPS];
    t_ctl             r_ctl [ROOT_STEPS];
    logic [TAG_W-1:0] r_tag [ROOT_STEPS];

    for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_step
        logic [ACC_W-1:0] w_n;
        logic [ACC_W-1:0] w_res;
        logic [ACC_W-1:0] w_bit;
        logic [ACC_W-1:0] w_try;
        t_ctl             w_ctl;
        logic [TAG_W-1:0] w_tag;

        if (g == 0) begin : g_first
            assign w_n   = ACC_W'(i_norm);
            assign w_res = '0;
            assign w_ctl = i_ctl;
            assign w_tag = i_tag;
        end else begin : g_next
            assign w_n   = r_n[g-1];
            assign w_res = r_res[g-1];
            assign w_ctl = r_ctl[g-1];
            assign w_tag = r_tag[g-1];
        end

        assign w_bit = ACC_W'(1) << (2 * (ROOT_STEPS - 1 - g));
        assign w_try = w_res + w_bit;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[g].vld <= 1'b0;
            end else if (i_en) begin
                r_ctl[g] <= w_ctl;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_res[g] <= (w_n >= w_try) ? (w_res >> 1) + w_bit : w_res >> 1;
                r_tag[g] <= w_tag;
            end
        end

        // The remainder is not needed after the last digit.
        if (g < ROOT_STEPS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_n[g] <= (w_n >= w_try) ? w_n - w_try : w_n;
                end
            end
        end
    end

    assign o_ctl  = r_ctl[ROOT_STEPS-1];
    assign o_root = r_res[ROOT_STEPS-1][ROOT_W-1:0];
    assign o_tag  = r_tag[ROOT_STEPS-1];

endmodule

>>> src/tlrg_recip.sv
// ----------------------------------------------------------------------------
// tlrg_recip
// Pipelined restoring divider for 2^62 / root, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tlrg_recip #(
    parameter int TAG_W = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  tlrg_pkg::t_ctl               i_ctl,
    input  logic [tlrg_pkg::ROOT_W-1:0]  i_root,
    input  logic [TAG_W-1:0]             i_tag,
    output tlrg_pkg::t_ctl               o_ctl,
    output logic [tlrg_pkg::RECIP_W-1:0] o_recip,
    output logic [TAG_W-1:0]             o_tag
);
    import tlrg_pkg::*;

    logic [REM_W-1:0]   r_rem [RECIP_STEPS-1];
    logic [ROOT_W-1:0]  r_div [RECIP_STEPS-1];
    logic [RECIP_W-1:0] r_q   [RECIP_STEPS];
    t_ctl               r_ctl [RECIP_STEPS];
    logic [TAG_W-1:0]   r_tag [RECIP_STEPS];

    for (genvar g = 0; g < RECIP_STEPS; g++) begin : g_step
        logic [REM_W-1:0]   w_rem;
        logic [ROOT_W-1:0]  w_div;
        logic [RECIP_W-1:0] w_q;
        t_ctl               w_ctl;
        logic [TAG_W-1:0]   w_tag;
        logic               w_ge;

        if (g == 0) begin : g_first
            // The dividend's bits from the quotient's top bit position up form the
            // first partial remainder.
            assign w_rem = REM_W'(1) << (RECIP_EXP - RECIP_STEPS + 1);
            assign w_div = i_root;
            assign w_q   = '0;
            assign w_ctl = i_ctl;
            assign w_tag = i_tag;
        end else begin : g_next
            assign w_rem = {r_rem[g-1][REM_W-2:0], 1'b0};
            assign w_div = r_div[g-1];
            assign w_q   = r_q[g-1];
            assign w_ctl = r_ctl[g-1];
            assign w_tag = r_tag[g-1];
        end

        assign w_ge = (w_rem >= REM_W'(w_div));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[g].vld <= 1'b0;
            end else if (i_en) begin
                r_ctl[g] <= w_ctl;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[g]   <= {w_q[RECIP_W-2:0], w_ge};
                r_tag[g] <= w_tag;
            end
        end

        if (g < RECIP_STEPS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g] <= w_ge ? w_rem - REM_W'(w_div) : w_rem;
                    r_div[g] <= w_div;
                end
            end
        end
    end

    assign o_ctl   = r_ctl[RECIP_STEPS-1];
    assign o_recip = r_q[RECIP_STEPS-1];
    assign o_tag   = r_tag[RECIP_STEPS-1];

endmodule

>>> src/tlrg_scale.sv
// ----------------------------------------------------------------------------
// tlrg_scale
// Scales the direction by the reciprocal length, rounds and saturates.
// ----------------------------------------------------------------------------
module tlrg_scale #(
    parameter int CW = tlrg_pkg::COMP_WIDTH_DEF,
    parameter int DW = tlrg_pkg::COMP_WIDTH_DEF + 4,
    parameter int FB = tlrg_pkg::DIR_FRAC_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  tlrg_pkg::t_ctl               i_ctl,
    input  logic [tlrg_pkg::RECIP_W-1:0] i_recip,
    input  logic [2:0]                   i_dneg,
    input  logic [3*DW-1:0]              i_dabs,
    input  logic [3*CW-1:0]              i_origin,
    output logic                         o_vld,
    output logic [3*(FB+1)-1:0]          o_dir,
    output logic [3*CW-1:0]              o_origin
);
    import tlrg_pkg::*;

    localparam int DIR_W = FB + 1;
    localparam int SFT   = RECIP_EXP - FB;
    localparam int QW    = ACC_W - SFT;
    localparam logic [QW-1:0] DIR_MAX = QW'((1 << FB) - 1);

    logic [2:0]           r_vld;
    logic [ROOT_W-1:0]    r_m [3];
    logic [RECIP_W-1:0]   r_rcp;
    logic [2:0]           r_neg_a, r_neg_b;
    logic                 r_zero_a, r_zero_b;
    logic [3*CW-1:0]      r_org_a, r_org_b, r_org_c;
    logic [ACC_W-1:0]     r_p [3];
    logic [3*DIR_W-1:0]   r_dir;

    logic [ACC_W-1:0]     w_wide [3];
    logic [QW-1:0]        w_q [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_ctl.vld};
        end
    end

    // |d| * 2^sh never exceeds the normalized root, so it fits the root width.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_wide[k] = ACC_W'(i_dabs[k*DW +: DW]) << i_ctl.sh;
            w_q[k]    = QW'((r_p[k] + (ACC_W'(1) << (SFT - 1))) >> SFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_m[k] <= w_wide[k][ROOT_W-1:0];
                r_p[k] <= ACC_W'(r_m[k]) * ACC_W'(r_rcp);
                if (r_zero_b) begin
                    r_dir[k*DIR_W +: DIR_W] <= '0;
                end else if (!r_neg_b[k]) begin
                    r_dir[k*DIR_W +: DIR_W] <= (w_q[k] > DIR_MAX) ? DIR_W'(DIR_MAX)
                                                                  : DIR_W'(w_q[k]);
                end else begin
                    r_dir[k*DIR_W +: DIR_W] <= (w_q[k] > DIR_MAX + QW'(1))
                                               ? DIR_W'(DIR_MAX + QW'(1))
                                               : DIR_W'(-w_q[k]);
                end
            end
            r_rcp    <= i_recip;
            r_neg_a  <= i_dneg;
            r_zero_a <= i_ctl.zero;
            r_org_a  <= i_origin;
            r_neg_b  <= r_neg_a;
            r_zero_b <= r_zero_a;
            r_org_b  <= r_org_a;
            r_org_c  <= r_org_b;
        end
    end

    assign o_vld    = r_vld[2];
    assign o_dir    = r_dir;
    assign o_origin = r_org_c;

endmodule

>>> src/thin_lens_ray_generator_core.sv
// ----------------------------------------------------------------------------
// thin_lens_ray_generator_core
// Thin-lens camera ray generator: one normalized ray per screen/lens sample.
// ----------------------------------------------------------------------------
//
//   channel      direction  contents
//   -----------  ---------  ------------------------------------------------
//   s_axis_*     in         request: screen u, v and lens sample x, y
//   m_axis_*     out        ray origin x, y, z and unit direction x, y, z
//   i_cfg_*      in         view registers: eye, corner, spans, lens axes, dof
//
// A request is taken every clock while the output is free or being taken.
// The steps run in order: offset, direction and normalization, then the
// square root (one digit per stage), the reciprocal (one quotient bit per
// stage), then scaling and saturation, the last being the output register.
// A stalled output freezes the whole pipeline; nothing is dropped.
// Reset is synchronous and active low; it clears the valid bits and sets the
// view registers to zero with depth of field enabled.
//
module thin_lens_ray_generator_core #(
    parameter int COMP_WIDTH    = tlrg_pkg::COMP_WIDTH_DEF,
    parameter int DIR_FRAC_BITS = tlrg_pkg::DIR_FRAC_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tlrg_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [tlrg_pkg::REG_W-1:0]         i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // screen_u, screen_v, lens_x, lens_y (16 bits each, from bit 0 up)
    input  logic [4*tlrg_pkg::IN_W-1:0]        s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // ray_origin_x, _y, _z (COMP_WIDTH each), ray_dir_x, _y, _z
    // (DIR_FRAC_BITS+1 each), from bit 0 up, zero padded to whole bytes
    output logic [((3*COMP_WIDTH + 3*(DIR_FRAC_BITS+1) + 7) / 8) * 8 - 1:0] m_axis_tdata
);
    import tlrg_pkg::*;

    localparam int DW    = COMP_WIDTH + 4;
    localparam int DIR_W = DIR_FRAC_BITS + 1;
    localparam int TAG_W = 3 * COMP_WIDTH + 3 + 3 * DW;
    localparam int OUT_W = ((3*COMP_WIDTH + 3*DIR_W + 7) / 8) * 8;

    logic [REG_W-1:0] r_eye, r_corner, r_hspan, r_vspan, r_right, r_up;
    logic             r_dof;

    logic                     w_en;
    t_ctl                     w_f_ctl, w_r_ctl, w_q_ctl;
    logic [NORM_W-1:0]        w_norm;
    logic [3*COMP_WIDTH-1:0]  w_f_org, w_s_org;
    logic [2:0]               w_f_neg;
    logic [3*DW-1:0]          w_f_abs;
    logic [TAG_W-1:0]         w_r_tag, w_q_tag;
    logic [ROOT_W-1:0]        w_root;
    logic [RECIP_W-1:0]       w_recip;
    logic [3*DIR_W-1:0]       w_dir;

    // View registers. The user writes only while no request is in flight; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eye    <= '0;
            r_corner <= '0;
            r_hspan  <= '0;
            r_vspan  <= '0;
            r_right  <= '0;
            r_up     <= '0;
            r_dof    <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_EYE:    r_eye    <= i_cfg_wdata;
                REG_CORNER: r_corner <= i_cfg_wdata;
                REG_HSPAN:  r_hspan  <= i_cfg_wdata;
                REG_VSPAN:  r_vspan  <= i_cfg_wdata;
                REG_RIGHT:  r_right  <= i_cfg_wdata;
                REG_UP:     r_up     <= i_cfg_wdata;
                REG_DOF:    r_dof    <= i_cfg_wdata[0];
                default:    ;
            endcase
        end
    end

    // Every stage moves together; the pipeline holds only while a finished
    // ray sits in the output register and is not being taken.
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    tlrg_front #(
        .CW(COMP_WIDTH),
        .DW(DW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_vld    (s_axis_tvalid),
        .i_u      (s_axis_tdata[IN_W-1:0]),
        .i_v      (s_axis_tdata[2*IN_W-1:IN_W]),
        .i_lx     ($signed(s_axis_tdata[3*IN_W-1:2*IN_W])),
        .i_ly     ($signed(s_axis_tdata[4*IN_W-1:3*IN_W])),
        .i_eye    (r_eye),
        .i_corner (r_corner),
        .i_hspan  (r_hspan),
        .i_vspan  (r_vspan),
        .i_right  (r_right),
        .i_up     (r_up),
        .i_dof    (r_dof),
        .o_ctl    (w_f_ctl),
        .o_norm   (w_norm),
        .o_origin (w_f_org),
        .o_dneg   (w_f_neg),
        .o_dabs   (w_f_abs)
    );

    // Origin and direction magnitudes ride along the root and divider stages.
    tlrg_isqrt #(
        .TAG_W(TAG_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_f_ctl),
        .i_norm  (w_norm),
        .i_tag   ({w_f_org, w_f_neg, w_f_abs}),
        .o_ctl   (w_r_ctl),
        .o_root  (w_root),
        .o_tag   (w_r_tag)
    );

    tlrg_recip #(
        .TAG_W(TAG_W)
    ) u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_r_ctl),
        .i_root  (w_root),
        .i_tag   (w_r_tag),
        .o_ctl   (w_q_ctl),
        .o_recip (w_recip),
        .o_tag   (w_q_tag)
    );

    tlrg_scale #(
        .CW(COMP_WIDTH),
        .DW(DW),
        .FB(DIR_FRAC_BITS)
    ) u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_ctl    (w_q_ctl),
        .i_recip  (w_recip),
        .i_dneg   (w_q_tag[3*DW+2:3*DW]),
        .i_dabs   (w_q_tag[3*DW-1:0]),
        .i_origin (w_q_tag[TAG_W-1:3*DW+3]),
        .o_vld    (m_axis_tvalid),
        .o_dir    (w_dir),
        .o_origin (w_s_org)
    );

    assign m_axis_tdata = OUT_W'({w_dir, w_s_org});

    // A nonzero squared length leaves normalization with a top bit pair set.
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_f_ctl.vld && !w_f_ctl.zero) |-> (w_norm[NORM_W-1] || w_norm[NORM_W-2]))
        else $error("normalized length out of range");

    // The root of a normalized length always has its top bit set.
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_r_ctl.vld && !w_r_ctl.zero) |-> w_root[ROOT_W-1])
        else $error("square root out of range");

    // The reciprocal of such a root lies in (2^31, 2^32].
    a_recip_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_ctl.vld && !w_q_ctl.zero) |->
            (w_recip[RECIP_W-1] || w_recip[RECIP_W-2]))
        else $error("reciprocal out of range");

    // While the output is held, requests inside the pipeline stay put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_r_ctl.vld) && $stable(w_q_ctl.vld))
        else $error("pipeline moved during a stall");

endmodule
